[sv/wtsp_pkg.sv]
// Package with the item types, register indexes and pipeline records of the projection block.
`timescale 1ns / 1ps
`default_nettype none
package wtsp_pkg;

  localparam int MAG_W   = 57;   // magnitude of a clip value, with headroom
  localparam int QBITS   = 44;   // ndc quotient bits below the saturation bit
  localparam int FRAC_W  = 24;   // fraction bits of ndc
  localparam int HALF_W  = 13;   // half of a 14-bit screen size
  localparam int CAP_SH  = 20;   // integer part of ndc saturates at 2^20
  localparam logic signed [63:0] W_MIN_Q32 = 64'sd429496730;

  typedef enum logic [2:0] {
    REG_ROW0_01 = 3'd0,
    REG_ROW0_23 = 3'd1,
    REG_ROW1_01 = 3'd2,
    REG_ROW1_23 = 3'd3,
    REG_ROW3_01 = 3'd4,
    REG_ROW3_23 = 3'd5,
    REG_SCR_W   = 3'd6,
    REG_SCR_H   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } out_t;

  // One divider stage: both axes share the divisor w.
  typedef struct packed {
    logic               valid;
    logic               vis;
    logic               neg_x;
    logic               neg_y;
    logic               cap_x;
    logic               cap_y;
    logic [MAG_W-1:0]   w;
    logic [MAG_W-1:0]   mag_x;
    logic [MAG_W-1:0]   mag_y;
    logic [MAG_W-1:0]   rem_x;
    logic [MAG_W-1:0]   rem_y;
    logic [QBITS-1:0]   quo_x;
    logic [QBITS-1:0]   quo_y;
    logic [HALF_W-1:0]  hw;
    logic [HALF_W-1:0]  hh;
  } div_t;

endpackage
`default_nettype wire

[sv/world_to_screen_projection.sv]
// Top level of the world-to-screen projection pipeline.
//
// Usage: a world point (point_x, point_y, point_z, signed Q16.16) enters on the
// in_valid/in_ready channel and one result item (visible, screen_x, screen_y)
// leaves on the out_valid/out_ready channel for every point, in order.
// The matrix rows 0, 1 and 3 and the screen size are set through the write port
// (cfg_we, cfg_index, cfg_data); the user must write them only while no item is
// in flight, which the block itself does not enforce. The pipeline has 49 register
// stages: a product stage, a summing stage, a setup stage, 44 restoring-division
// stages (one quotient bit each for x and y against the shared clip w), a viewport
// multiply stage and the output register. One item enters per cycle unless stalled.
// The whole pipeline advances together; when the receiver holds out_ready
// low with a result waiting, every stage holds and in_ready drops, so
// nothing is lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears every valid bit and loads the identity-like default matrix
// and a 1920 by 1080 screen.
// Points whose clip w is below 0.1 come out with visible low and zero
// coordinates; screen coordinates saturate to the signed Q16.16 range.
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projection (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire wtsp_pkg::in_t  in_data,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      wtsp_pkg::out_t out_data,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [63:0]    cfg_data
);

  localparam int MW = wtsp_pkg::MAG_W;
  localparam int QB = wtsp_pkg::QBITS;
  localparam int HW = wtsp_pkg::HALF_W;

  // Configuration registers.
  logic [63:0] row0_01, row0_23, row1_01, row1_23, row3_01, row3_23;
  logic [13:0] scr_w, scr_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0_01 <= 64'd16777216;
      row0_23 <= 64'd0;
      row1_01 <= 64'd72057594037927936;
      row1_23 <= 64'd0;
      row3_01 <= 64'd0;
      row3_23 <= 64'd72057594037927936;
      scr_w   <= 14'd1920;
      scr_h   <= 14'd1080;
    end else if (cfg_we) begin
      unique case (wtsp_pkg::cfg_idx_t'(cfg_index))
        wtsp_pkg::REG_ROW0_01: row0_01 <= cfg_data;
        wtsp_pkg::REG_ROW0_23: row0_23 <= cfg_data;
        wtsp_pkg::REG_ROW1_01: row1_01 <= cfg_data;
        wtsp_pkg::REG_ROW1_23: row1_23 <= cfg_data;
        wtsp_pkg::REG_ROW3_01: row3_01 <= cfg_data;
        wtsp_pkg::REG_ROW3_23: row3_23 <= cfg_data;
        wtsp_pkg::REG_SCR_W:   scr_w   <= cfg_data[13:0];
        wtsp_pkg::REG_SCR_H:   scr_h   <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one; it holds only when a result waits unread.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: nine products, Q16.16 x Q8.24.
  logic               p1_valid;
  logic signed [63:0] p1_xa, p1_yb, p1_zc, p1_ya, p1_yy, p1_yz, p1_wx, p1_wy, p1_wz;
  logic signed [31:0] p1_dx, p1_dy, p1_dw;

  always_ff @(posedge clk) begin
    if (rst) p1_valid <= 1'b0;
    else if (en) p1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_xa <= 64'(in_data.point_x) * 64'($signed(row0_01[31:0]));
      p1_yb <= 64'(in_data.point_y) * 64'($signed(row0_01[63:32]));
      p1_zc <= 64'(in_data.point_z) * 64'($signed(row0_23[31:0]));
      p1_ya <= 64'(in_data.point_x) * 64'($signed(row1_01[31:0]));
      p1_yy <= 64'(in_data.point_y) * 64'($signed(row1_01[63:32]));
      p1_yz <= 64'(in_data.point_z) * 64'($signed(row1_23[31:0]));
      p1_wx <= 64'(in_data.point_x) * 64'($signed(row3_01[31:0]));
      p1_wy <= 64'(in_data.point_y) * 64'($signed(row3_01[63:32]));
      p1_wz <= 64'(in_data.point_z) * 64'($signed(row3_23[31:0]));
      p1_dx <= $signed(row0_23[63:32]);
      p1_dy <= $signed(row1_23[63:32]);
      p1_dw <= $signed(row3_23[63:32]);
    end
  end

  // Stage 2: each product floors to Q.32, the translation scales by 256.
  logic               p2_valid;
  logic signed [63:0] p2_cx, p2_cy, p2_cw;
  logic [HW-1:0]      p2_hw, p2_hh;

  always_ff @(posedge clk) begin
    if (rst) p2_valid <= 1'b0;
    else if (en) p2_valid <= p1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_cx <= (p1_xa >>> 8) + (p1_yb >>> 8) + (p1_zc >>> 8) + (64'(p1_dx) <<< 8);
      p2_cy <= (p1_ya >>> 8) + (p1_yy >>> 8) + (p1_yz >>> 8) + (64'(p1_dy) <<< 8);
      p2_cw <= (p1_wx >>> 8) + (p1_wy >>> 8) + (p1_wz >>> 8) + (64'(p1_dw) <<< 8);
      p2_hw <= scr_w[13:1];
      p2_hh <= scr_h[13:1];
    end
  end

  // Stage 3: visibility, magnitudes, saturation check and first remainder.
  logic [MW-1:0] s3_magx, s3_magy, s3_w;
  wtsp_pkg::div_t dv [0:QB];

  always_comb begin
    s3_magx = p2_cx[63] ? MW'(-p2_cx) : p2_cx[MW-1:0];
    s3_magy = p2_cy[63] ? MW'(-p2_cy) : p2_cy[MW-1:0];
    s3_w    = p2_cw[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0].valid <= 1'b0;
    else if (en) dv[0].valid <= p2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].vis   <= (p2_cw >= wtsp_pkg::W_MIN_Q32);
      dv[0].neg_x <= p2_cx[63];
      dv[0].neg_y <= p2_cy[63];
      dv[0].cap_x <= {20'd0, s3_magx} >= {s3_w, 20'd0};
      dv[0].cap_y <= {20'd0, s3_magy} >= {s3_w, 20'd0};
      dv[0].w     <= s3_w;
      dv[0].mag_x <= s3_magx;
      dv[0].mag_y <= s3_magy;
      dv[0].rem_x <= s3_magx >> wtsp_pkg::CAP_SH;
      dv[0].rem_y <= s3_magy >> wtsp_pkg::CAP_SH;
      dv[0].quo_x <= '0;
      dv[0].quo_y <= '0;
      dv[0].hw    <= p2_hw;
      dv[0].hh    <= p2_hh;
    end
  end

  // Division stages: stage k yields quotient bit QB-1-k of (mag << 24) / w.
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BIT = QB - 1 - k;
    logic          dbx, dby;
    logic [MW:0]   tx, ty;
    logic          gex, gey;

    // The fraction bits of the dividend are zero.
    if (BIT >= wtsp_pkg::FRAC_W) begin : g_bit
      assign dbx = dv[k].mag_x[BIT - wtsp_pkg::FRAC_W];
      assign dby = dv[k].mag_y[BIT - wtsp_pkg::FRAC_W];
    end else begin : g_zero
      assign dbx = 1'b0;
      assign dby = 1'b0;
    end

    always_comb begin
      tx  = {dv[k].rem_x, dbx};
      ty  = {dv[k].rem_y, dby};
      gex = tx >= {1'b0, dv[k].w};
      gey = ty >= {1'b0, dv[k].w};
    end

    always_ff @(posedge clk) begin
      if (rst) dv[k+1].valid <= 1'b0;
      else if (en) dv[k+1].valid <= dv[k].valid;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1].vis   <= dv[k].vis;
        dv[k+1].neg_x <= dv[k].neg_x;
        dv[k+1].neg_y <= dv[k].neg_y;
        dv[k+1].cap_x <= dv[k].cap_x;
        dv[k+1].cap_y <= dv[k].cap_y;
        dv[k+1].w     <= dv[k].w;
        dv[k+1].mag_x <= dv[k].mag_x;
        dv[k+1].mag_y <= dv[k].mag_y;
        dv[k+1].rem_x <= gex ? MW'(tx - {1'b0, dv[k].w}) : tx[MW-1:0];
        dv[k+1].rem_y <= gey ? MW'(ty - {1'b0, dv[k].w}) : ty[MW-1:0];
        dv[k+1].quo_x <= dv[k].quo_x | (QB'(gex) << BIT);
        dv[k+1].quo_y <= dv[k].quo_y | (QB'(gey) << BIT);
        dv[k+1].hw    <= dv[k].hw;
        dv[k+1].hh    <= dv[k].hh;
      end
    end
  end

  // Viewport multiply: half size times ndc, truncated to Q16.16.
  logic [QB:0]          ndc_x, ndc_y;
  logic [QB+HW:0]       prod_x, prod_y;
  logic                 m_valid, m_vis, m_negx, m_negy;
  logic [QB+HW-8:0]     m_tx, m_ty;
  logic [HW-1:0]        m_hw, m_hh;

  always_comb begin
    ndc_x  = dv[QB].cap_x ? ((QB+1)'(1) << QB) : {1'b0, dv[QB].quo_x};
    ndc_y  = dv[QB].cap_y ? ((QB+1)'(1) << QB) : {1'b0, dv[QB].quo_y};
    prod_x = (QB+HW+1)'(dv[QB].hw) * (QB+HW+1)'(ndc_x);
    prod_y = (QB+HW+1)'(dv[QB].hh) * (QB+HW+1)'(ndc_y);
  end

  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else if (en) m_valid <= dv[QB].valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_vis  <= dv[QB].vis;
      m_negx <= dv[QB].neg_x;
      m_negy <= dv[QB].neg_y;
      m_tx   <= prod_x[QB+HW:8];
      m_ty   <= prod_y[QB+HW:8];
      m_hw   <= dv[QB].hw;
      m_hh   <= dv[QB].hh;
    end
  end

  // Output stage: center offset plus or minus the term, then saturation.
  localparam int SW = QB + HW - 5;
  logic signed [SW-1:0] base_x, base_y, term_x, term_y, sum_x, sum_y;
  logic signed [31:0]   sat_x, sat_y;

  always_comb begin
    base_x = $signed(SW'(m_hw) << 16);
    base_y = $signed(SW'(m_hh) << 16);
    term_x = m_negx ? -$signed(SW'(m_tx)) : $signed(SW'(m_tx));
    term_y = m_negy ? -$signed(SW'(m_ty)) : $signed(SW'(m_ty));
    sum_x  = base_x + term_x;
    sum_y  = base_y - term_y;
    if (sum_x > $signed(SW'(32'h7fffffff)))        sat_x = 32'sh7fffffff;
    else if (sum_x < -$signed(SW'(33'h080000000))) sat_x = 32'sh80000000;
    else                                           sat_x = sum_x[31:0];
    if (sum_y > $signed(SW'(32'h7fffffff)))        sat_y = 32'sh7fffffff;
    else if (sum_y < -$signed(SW'(33'h080000000))) sat_y = 32'sh80000000;
    else                                           sat_y = sum_y[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= m_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.visible  <= m_vis;
      out_data.screen_x <= m_vis ? sat_x : 32'sd0;
      out_data.screen_y <= m_vis ? sat_y : 32'sd0;
    end
  end

endmodule
`default_nettype wire

[sv/wtsp_checker.sv]
// Port-level checker for the projection block and its bind.
`timescale 1ns / 1ps
`default_nettype none
module wtsp_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire wtsp_pkg::out_t out_data
);

  // A result that waits is held until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // Points behind the near limit carry zero coordinates.
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.visible |-> out_data.screen_x == 32'sd0 &&
                                       out_data.screen_y == 32'sd0)
    else $error("hidden point with nonzero coordinates");

  // With no result pending the block always takes an item.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind world_to_screen_projection wtsp_checker u_wtsp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[tb/sv/projection_checker.sv]
// Checker that predicts and compares the projected screen items of the block.
`timescale 1ns / 1ps
module projection_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_ready,
  input  wire wtsp_pkg::in_t  in_data,
  input  wire logic           out_valid,
  input  wire logic           out_ready,
  input  wire wtsp_pkg::out_t out_data,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [63:0]    cfg_data,
  output int                  fail_count,
  output int                  pending
);

  logic [63:0] matrix_regs [6];
  logic [13:0] scr_w, scr_h;
  wtsp_pkg::out_t screen_queue [$];

  assign pending = screen_queue.size();

  function automatic longint floor_shr8(longint p);
    return p >>> 8;
  endfunction

  function automatic longint row_sum(logic [63:0] r01, logic [63:0] r23, wtsp_pkg::in_t p);
    longint a, b, c, d;
    a = longint'($signed(r01[31:0]));
    b = longint'($signed(r01[63:32]));
    c = longint'($signed(r23[31:0]));
    d = longint'($signed(r23[63:32]));
    return floor_shr8(longint'(p.point_x) * a) + floor_shr8(longint'(p.point_y) * b)
         + floor_shr8(longint'(p.point_z) * c) + d * 256;
  endfunction

  // Signed Q16.16 value of half * (c / w), with the ndc integer part capped.
  // The fraction comes one bit at a time so the remainder never overflows.
  function automatic longint scaled_ndc(longint c, longint w, longint unsigned half);
    longint unsigned mag, uw, q, r, frac, ndc, t;
    mag = (c < 0) ? -c : c;
    uw = w;
    q = mag / uw;
    r = mag % uw;
    frac = 0;
    if (q >= 64'd1048576) begin
      ndc = 64'd1048576 << 24;
    end else begin
      for (int i = 0; i < 24; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= uw) begin
          r = r - uw;
          frac = frac | 64'd1;
        end
      end
      ndc = (q << 24) | frac;
    end
    t = (half * ndc) >> 8;
    return (c < 0) ? -longint'(t) : longint'(t);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic wtsp_pkg::out_t project_point(wtsp_pkg::in_t p);
    wtsp_pkg::out_t o;
    longint cx, cy, cw;
    longint unsigned hw, hh;
    cx = row_sum(matrix_regs[0], matrix_regs[1], p);
    cy = row_sum(matrix_regs[2], matrix_regs[3], p);
    cw = row_sum(matrix_regs[4], matrix_regs[5], p);
    hw = scr_w >> 1;
    hh = scr_h >> 1;
    o = '0;
    if (cw >= wtsp_pkg::W_MIN_Q32) begin
      o.visible = 1'b1;
      o.screen_x = clamp32(longint'(hw * 65536) + scaled_ndc(cx, cw, hw));
      o.screen_y = clamp32(longint'(hh * 65536) - scaled_ndc(cy, cw, hh));
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    wtsp_pkg::out_t want;
    if (rst) begin
      matrix_regs[0] <= 64'd16777216;
      matrix_regs[1] <= 64'd0;
      matrix_regs[2] <= 64'd72057594037927936;
      matrix_regs[3] <= 64'd0;
      matrix_regs[4] <= 64'd0;
      matrix_regs[5] <= 64'd72057594037927936;
      scr_w <= 14'd1920;
      scr_h <= 14'd1080;
    end else begin
      // The write lands at this edge, so points accepted here still use the old setup.
      if (in_valid && in_ready) screen_queue.push_back(project_point(in_data));
      if (out_valid && out_ready) begin
        if (screen_queue.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          want = screen_queue.pop_front();
          if (out_data.visible !== want.visible)
            report_mismatch("visible", out_data.visible, want.visible);
          if (out_data.screen_x !== want.screen_x)
            report_mismatch("screen_x", out_data.screen_x, want.screen_x);
          if (out_data.screen_y !== want.screen_y)
            report_mismatch("screen_y", out_data.screen_y, want.screen_y);
        end
      end
      if (cfg_we) begin
        if (cfg_index == wtsp_pkg::REG_SCR_W) scr_w <= cfg_data[13:0];
        else if (cfg_index == wtsp_pkg::REG_SCR_H) scr_h <= cfg_data[13:0];
        else matrix_regs[cfg_index] <= cfg_data;
      end
    end
  end
endmodule

[tb/sv/tb.sv]
// Top of the projection testbench: stimulus, setup phases and verdict.
`timescale 1ns / 1ps
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  wtsp_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wtsp_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int fail_count, pending;
  bit calm_tail = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  world_to_screen_projection dut (.*);

  projection_checker chk (.*);

  // Receiver: random stall bursts, none in the last part of the run.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Q8.24 value from a real number, for readable matrix setups.
  function automatic logic [31:0] q824(real v);
    return 32'($rtoi(v * 16777216.0));
  endfunction

  // One write, then the enable drops again before the next write.
  task automatic write_reg(wtsp_pkg::cfg_idx_t idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected item, then the pipeline depth, before a register write.
  task automatic drain;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_point(wtsp_pkg::in_t p);
    int n;
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic end_burst;
    in_valid <= 1'b0;
  endtask

  function automatic wtsp_pkg::in_t rand_point(int mode);
    wtsp_pkg::in_t p;
    p.point_x = $urandom();
    p.point_y = $urandom();
    p.point_z = $urandom();
    if (mode == 1) begin
      // Points in a camera-friendly range, mostly in front of the camera.
      p.point_x = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
      p.point_y = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
      p.point_z = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0001_0000;
    end
    return p;
  endfunction

  task automatic random_setup(int flavor);
    logic [63:0] v;
    if (flavor == 0) begin
      write_reg(wtsp_pkg::REG_ROW0_01, {$urandom(), $urandom()});
      write_reg(wtsp_pkg::REG_ROW0_23, {$urandom(), $urandom()});
      write_reg(wtsp_pkg::REG_ROW1_01, {$urandom(), $urandom()});
      write_reg(wtsp_pkg::REG_ROW1_23, {$urandom(), $urandom()});
      write_reg(wtsp_pkg::REG_ROW3_01, {$urandom(), $urandom()});
      write_reg(wtsp_pkg::REG_ROW3_23, {$urandom(), $urandom()});
    end else begin
      // Perspective-like matrix with small random skew; w follows z.
      write_reg(wtsp_pkg::REG_ROW0_01, {q824($urandom_range(0, 200) / 100.0 - 1.0),
                                        q824($urandom_range(50, 300) / 100.0)});
      write_reg(wtsp_pkg::REG_ROW0_23, {q824($urandom_range(0, 40) - 20.0),
                                        q824($urandom_range(0, 100) / 100.0 - 0.5)});
      write_reg(wtsp_pkg::REG_ROW1_01, {q824($urandom_range(50, 300) / 100.0),
                                        q824($urandom_range(0, 100) / 100.0 - 0.5)});
      write_reg(wtsp_pkg::REG_ROW1_23, {q824($urandom_range(0, 40) - 20.0),
                                        q824($urandom_range(0, 100) / 100.0 - 0.5)});
      write_reg(wtsp_pkg::REG_ROW3_01, {q824($urandom_range(0, 20) / 100.0 - 0.1),
                                        q824($urandom_range(0, 20) / 100.0 - 0.1)});
      write_reg(wtsp_pkg::REG_ROW3_23, {q824($urandom_range(0, 40) / 10.0 - 1.0),
                                        q824(1.0)});
    end
    v = $urandom_range(0, 3);
    write_reg(wtsp_pkg::REG_SCR_W,
              (v == 0) ? 64'd8192 : (v == 1) ? 64'd1 : 64'($urandom_range(1, 8192)));
    v = $urandom_range(0, 3);
    write_reg(wtsp_pkg::REG_SCR_H,
              (v == 0) ? 64'd8191 : (v == 1) ? 64'd2 : 64'($urandom_range(1, 8192)));
  endtask

  initial begin
    wtsp_pkg::in_t p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed points under the reset setup: identity x and y rows, w fixed at 1.0.
    p = '{32'sd0, 32'sd0, 32'sd0};                          send_point(p);
    p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};     send_point(p);
    p = '{32'sh80000000, 32'sh80000000, 32'sh80000000};     send_point(p);
    p = '{32'sh7fffffff, 32'sh80000000, 32'sd0};            send_point(p);
    p = '{32'sh80000000, 32'sh7fffffff, 32'sd0};            send_point(p);
    end_burst();
    drain();

    // Now w is 1.0 plus z, and x has a gain near 128 so a point near the limit
    // drives ndc into its cap.
    write_reg(wtsp_pkg::REG_ROW0_01, {32'h0000_0000, 32'h7fff_ffff});
    write_reg(wtsp_pkg::REG_ROW3_23, {q824(1.0), q824(1.0)});
    // Just below and just above the visibility threshold of w.
    p = '{32'sd65536, 32'sd65536, -32'sd58983};             send_point(p);
    p = '{32'sd65536, 32'sd65536, -32'sd58982};             send_point(p);
    p = '{32'sd65536, -32'sd65536, 32'sd0};                 send_point(p);
    p = '{-32'sd1, -32'sd1, -32'sd65536};                   send_point(p);
    // Huge ndc that reaches the integer cap.
    p = '{32'sh7fffffff, 32'sh80000000, -32'sd58982};       send_point(p);
    end_burst();
    drain();

    // Extremes: all-ones and all-zero registers, degenerate screen sizes.
    write_reg(wtsp_pkg::REG_ROW0_01, '1);
    write_reg(wtsp_pkg::REG_ROW0_23, '1);
    write_reg(wtsp_pkg::REG_ROW1_01, {32'h8000_0000, 32'h7fff_ffff});
    write_reg(wtsp_pkg::REG_ROW1_23, {32'h7fff_ffff, 32'h8000_0000});
    write_reg(wtsp_pkg::REG_ROW3_01, '0);
    write_reg(wtsp_pkg::REG_ROW3_23, {32'h7fff_ffff, 32'h0000_0000});
    write_reg(wtsp_pkg::REG_SCR_W, 64'd1);
    write_reg(wtsp_pkg::REG_SCR_H, 64'd8192);
    p = '{32'sd0, 32'sd0, 32'sd65536};                      send_point(p);
    p = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};     send_point(p);
    p = '{32'sh80000000, 32'sh7fffffff, 32'sd1};            send_point(p);
    p = '{32'sd12345, -32'sd98765, 32'sh4000_0000};         send_point(p);
    end_burst();
    drain();

    // Random phases; most use perspective-like setups so many points are visible.
    for (int ph = 0; ph < 19; ph++) begin
      random_setup(($urandom_range(0, 3) == 0) ? 0 : 1);
      if (ph == 18) calm_tail = 1'b1;
      for (int i = 0; i < 50; i++) begin
        send_point(rand_point(($urandom_range(0, 4) == 0) ? 0 : 1));
      end
      end_burst();
      drain();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
